// ----- hw/rtl/gfm_pkg.sv -----
// shared types, constants and carry-less helper functions for the gf(2^128) mac pipeline
// no dependencies
package gfm_pkg;

    localparam int WORD_W     = 64;
    localparam int ELEM_W     = 2 * WORD_W;
    localparam int HALF_W     = WORD_W / 2;
    localparam int PP_W       = WORD_W + HALF_W - 1;
    localparam int NUM_PP     = 8;
    localparam int CFG_INDEX_W = 8;

    localparam logic [7:0] POLY_TAIL = 8'h87;

    localparam logic [CFG_INDEX_W-1:0] REG_MULT_LO = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MULT_HI = CFG_INDEX_W'(1);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ELEM_W-1:0] elem_t;
    typedef logic [PP_W-1:0]   pp_t;

    // partial products: index 2*n + h, n = ll, lh, hl, hh, h = half of multiplier word
    typedef struct packed {
        pp_t [NUM_PP-1:0] pp;
        elem_t            acc;
    } mul_stage_t;

    typedef struct packed {
        word_t p2;
        word_t p1;
        word_t p0;
        elem_t acc;
    } fold_stage_t;

    // 64 x 32 carry-less product, each output bit an independent parity
    function automatic pp_t clmul64x32(input word_t a, input logic [HALF_W-1:0] b);
        pp_t                r;
        logic [HALF_W-1:0]  v;
        int                 idx;
        r = '0;
        for (int k = 0; k < PP_W; k++) begin
            v = '0;
            for (int j = 0; j < HALF_W; j++) begin
                idx = k - j;
                if (idx >= 0 && idx < WORD_W) begin
                    v[j] = a[idx[5:0]] & b[j];
                end
            end
            r[k] = ^v;
        end
        return r;
    endfunction

    // multiply a word by the reduction tail
    function automatic elem_t fold_tail(input word_t a);
        elem_t r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (POLY_TAIL[i]) begin
                r = r ^ (elem_t'(a) << i);
            end
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/gfm_mul_stage.sv -----
// first pipeline stage: eight 64x32 carry-less partial products
// depends on gfm_pkg
module gfm_mul_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  gfm_pkg::word_t      x_lo,
    input  gfm_pkg::word_t      x_hi,
    input  gfm_pkg::elem_t      acc,
    input  gfm_pkg::word_t      mult_lo,
    input  gfm_pkg::word_t      mult_hi,
    output logic                out_valid,
    input  logic                out_ready,
    output gfm_pkg::mul_stage_t out_data
);
    import gfm_pkg::*;

    logic       valid_reg;
    mul_stage_t data_reg;
    mul_stage_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next.acc   = acc;
        data_next.pp[0] = clmul64x32(x_lo, mult_lo[HALF_W-1:0]);
        data_next.pp[1] = clmul64x32(x_lo, mult_lo[WORD_W-1:HALF_W]);
        data_next.pp[2] = clmul64x32(x_lo, mult_hi[HALF_W-1:0]);
        data_next.pp[3] = clmul64x32(x_lo, mult_hi[WORD_W-1:HALF_W]);
        data_next.pp[4] = clmul64x32(x_hi, mult_lo[HALF_W-1:0]);
        data_next.pp[5] = clmul64x32(x_hi, mult_lo[WORD_W-1:HALF_W]);
        data_next.pp[6] = clmul64x32(x_hi, mult_hi[HALF_W-1:0]);
        data_next.pp[7] = clmul64x32(x_hi, mult_hi[WORD_W-1:HALF_W]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/gfm_fold_stage.sv -----
// second pipeline stage: assemble the 256-bit product and fold the top word
// depends on gfm_pkg
module gfm_fold_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gfm_pkg::mul_stage_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gfm_pkg::fold_stage_t out_data
);
    import gfm_pkg::*;

    logic        valid_reg;
    fold_stage_t data_reg;
    fold_stage_t data_next;

    elem_t       c_ll;
    elem_t       c_lh;
    elem_t       c_hl;
    elem_t       c_hh;
    logic [2*ELEM_W-1:0] prod;
    elem_t       f;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        c_ll = elem_t'(in_data.pp[0]) ^ (elem_t'(in_data.pp[1]) << HALF_W);
        c_lh = elem_t'(in_data.pp[2]) ^ (elem_t'(in_data.pp[3]) << HALF_W);
        c_hl = elem_t'(in_data.pp[4]) ^ (elem_t'(in_data.pp[5]) << HALF_W);
        c_hh = elem_t'(in_data.pp[6]) ^ (elem_t'(in_data.pp[7]) << HALF_W);
        prod = {c_hh, c_ll} ^ ({ELEM_W'(0), c_lh ^ c_hl} << WORD_W);
        f    = fold_tail(prod[4*WORD_W-1:3*WORD_W]);
        data_next.acc = in_data.acc;
        data_next.p0  = prod[WORD_W-1:0];
        data_next.p1  = prod[2*WORD_W-1:WORD_W] ^ f[WORD_W-1:0];
        data_next.p2  = prod[3*WORD_W-1:2*WORD_W] ^ f[ELEM_W-1:WORD_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/gfm_out_stage.sv -----
// last pipeline stage: second fold, accumulator xor and the output register
// depends on gfm_pkg
module gfm_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gfm_pkg::fold_stage_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gfm_pkg::word_t       sum_lo,
    output gfm_pkg::word_t       sum_hi
);
    import gfm_pkg::*;

    logic  valid_reg;
    elem_t sum_reg;
    elem_t sum_next;
    elem_t g;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        g        = fold_tail(in_data.p2);
        sum_next = in_data.acc ^ {in_data.p1, in_data.p0} ^ g;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = valid_reg;
    assign sum_lo    = sum_reg[WORD_W-1:0];
    assign sum_hi    = sum_reg[ELEM_W-1:WORD_W];

endmodule

// ----- hw/rtl/gf2_128_multiply_accumulate.sv -----
// gf(2^128) multiply-accumulate against a configured multiplier, three register stages
// a result passes the mul, fold and out stage registers before it is offered on m_valid
// throughput: one transaction per cycle while m_ready is high,
// each stage refills in the cycle that it drains
// reset: synchronous active-low aresetn clears the stage valid bits and both multiplier words
// depends on gfm_pkg, gfm_mul_stage, gfm_fold_stage, gfm_out_stage
module gf2_128_multiply_accumulate (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gfm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  gfm_pkg::word_t                    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  gfm_pkg::word_t                    s_x_lo,
    input  gfm_pkg::word_t                    s_x_hi,
    input  gfm_pkg::word_t                    s_acc_lo,
    input  gfm_pkg::word_t                    s_acc_hi,
    output logic                              m_valid,
    input  logic                              m_ready,
    output gfm_pkg::word_t                    m_sum_lo,
    output gfm_pkg::word_t                    m_sum_hi
);
    import gfm_pkg::*;

    word_t       mult_lo_reg;
    word_t       mult_hi_reg;

    logic        a_valid;
    logic        a_ready;
    mul_stage_t  a_data;
    logic        b_valid;
    logic        b_ready;
    fold_stage_t b_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_lo_reg <= '0;
            mult_hi_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_MULT_LO) begin
                mult_lo_reg <= cfg_data;
            end
            if (cfg_index == REG_MULT_HI) begin
                mult_hi_reg <= cfg_data;
            end
        end
    end

    gfm_mul_stage u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .x_lo      (s_x_lo),
        .x_hi      (s_x_hi),
        .acc       ({s_acc_hi, s_acc_lo}),
        .mult_lo   (mult_lo_reg),
        .mult_hi   (mult_hi_reg),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_data  (a_data)
    );

    gfm_fold_stage u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_data   (a_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    gfm_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_data   (b_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .sum_lo    (m_sum_lo),
        .sum_hi    (m_sum_hi)
    );

    a_reset_clears_output: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_full_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid && b_valid && m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while pipeline full and stalled");

    a_empty_stage_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !a_valid |-> s_ready)
        else $error("input refused with first stage empty");

    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid && !b_ready) |=> (b_valid && $stable(b_data)))
        else $error("fold stage changed while stalled");

endmodule

// ----- sim/gfm_mac_checker.sv -----
// watches the configuration, input and result channels of the gf(2^128) mac block,
// predicts every result and compares it with what the block returns
// depends on gfm_pkg
module gfm_mac_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [gfm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  gfm_pkg::word_t                  cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  gfm_pkg::word_t                  s_x_lo,
    input  gfm_pkg::word_t                  s_x_hi,
    input  gfm_pkg::word_t                  s_acc_lo,
    input  gfm_pkg::word_t                  s_acc_hi,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  gfm_pkg::word_t                  m_sum_lo,
    input  gfm_pkg::word_t                  m_sum_hi,
    output int                              mismatches,
    output int                              outstanding
);
    import gfm_pkg::*;

    // x^128 + x^7 + x^2 + x + 1 at double width
    localparam logic [2*ELEM_W-1:0] FIELD_POLY =
        {{(ELEM_W-1){1'b0}}, 1'b1, {(ELEM_W-8){1'b0}}, POLY_TAIL};

    word_t multiplier_lo;
    word_t multiplier_hi;
    elem_t expected_sums[$];
    elem_t want;
    int    fail_count = 0;
    int    result_count = 0;

    function automatic elem_t gf_mac(input elem_t x, input elem_t m, input elem_t acc);
        logic [2*ELEM_W-1:0] prod;
        prod = '0;
        for (int i = 0; i < ELEM_W; i++) begin
            if (m[i]) begin
                prod = prod ^ ({{ELEM_W{1'b0}}, x} << i);
            end
        end
        // reduce from the top coefficient down
        for (int i = 2*ELEM_W-1; i >= ELEM_W; i--) begin
            if (prod[i]) begin
                prod = prod ^ (FIELD_POLY << (i - ELEM_W));
            end
        end
        return acc ^ prod[ELEM_W-1:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            multiplier_lo = '0;
            multiplier_hi = '0;
            expected_sums.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_sums.size() == 0) begin
                    fail_count++;
                    $display("%0t: result transaction %0d with nothing expected, got %h %h",
                             $time, result_count, m_sum_hi, m_sum_lo);
                end else begin
                    want = expected_sums.pop_front();
                    if (m_sum_lo !== want[WORD_W-1:0]) begin
                        fail_count++;
                        $display("%0t: result %0d sum_lo expected %h got %h",
                                 $time, result_count, want[WORD_W-1:0], m_sum_lo);
                    end
                    if (m_sum_hi !== want[ELEM_W-1:WORD_W]) begin
                        fail_count++;
                        $display("%0t: result %0d sum_hi expected %h got %h",
                                 $time, result_count, want[ELEM_W-1:WORD_W], m_sum_hi);
                    end
                end
                result_count++;
            end
            if (s_valid && s_ready) begin
                expected_sums.push_back(gf_mac({s_x_hi, s_x_lo},
                                               {multiplier_hi, multiplier_lo},
                                               {s_acc_hi, s_acc_lo}));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MULT_LO: multiplier_lo = cfg_data;
                    REG_MULT_HI: multiplier_hi = cfg_data;
                    default: ;
                endcase
            end
        end
        mismatches  <= fail_count;
        outstanding <= expected_sums.size();
    end

endmodule

// ----- sim/tb.sv -----
// top of the gf(2^128) mac testbench: clock, reset, stimulus, receiver stalls and verdict
// depends on gfm_pkg, gf2_128_multiply_accumulate and gfm_mac_checker
module tb;
    import gfm_pkg::*;

    localparam int    WATCHDOG_LIMIT = 4000;
    localparam int    SETTLE_CYCLES  = 8;
    localparam int    HOLD_CYCLES    = 400;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = REG_MULT_HI + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = '1;
    localparam word_t ALL_ONES = '1;
    localparam word_t ALT_A    = 64'haaaa_aaaa_aaaa_aaaa;
    localparam word_t ALT_5    = ~ALT_A;
    localparam word_t TOP_BIT  = word_t'(1) << (WORD_W - 1);
    localparam word_t UNIT     = word_t'(1);

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    word_t                  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    word_t                  s_x_lo;
    word_t                  s_x_hi;
    word_t                  s_acc_lo;
    word_t                  s_acc_hi;
    logic                   m_valid;
    logic                   m_ready;
    word_t                  m_sum_lo;
    word_t                  m_sum_hi;
    int                     mismatches;
    int                     outstanding;
    int                     idle_cycles = 0;
    logic                   squeeze;

    always #5 aclk = ~aclk;

    gf2_128_multiply_accumulate u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_x_lo    (s_x_lo),
        .s_x_hi    (s_x_hi),
        .s_acc_lo  (s_acc_lo),
        .s_acc_hi  (s_acc_hi),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_sum_lo  (m_sum_lo),
        .m_sum_hi  (m_sum_hi)
    );

    gfm_mac_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_x_lo      (s_x_lo),
        .s_x_hi      (s_x_hi),
        .s_acc_lo    (s_acc_lo),
        .s_acc_hi    (s_acc_hi),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sum_lo    (m_sum_lo),
        .m_sum_hi    (m_sum_hi),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic word_t pick_word();
        int kind;
        kind = $urandom_range(0, 15);
        case (kind)
            0: return '0;
            1: return ALL_ONES;
            2: return UNIT << $urandom_range(0, WORD_W - 1);
            3: return {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic offer(input word_t xl, input word_t xh, input word_t al, input word_t ah);
        s_valid  <= 1'b1;
        s_x_lo   <= xl;
        s_x_hi   <= xh;
        s_acc_lo <= al;
        s_acc_hi <= ah;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering and let every outstanding result drain out
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_multiplier(input word_t lo, input word_t hi);
        settle();
        if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_MULT_LO, lo);
            write_reg(REG_MULT_HI, hi);
        end else begin
            write_reg(REG_MULT_HI, hi);
            write_reg(REG_MULT_LO, lo);
        end
        // unused index, must leave the multiplier alone
        write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), pick_word());
    endtask

    task automatic run_random(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 48);
            for (int i = 0; i < burst && sent < count; i++) begin
                offer(pick_word(), pick_word(), pick_word(), pick_word());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // receiver stalls on stretches of random density, plus one long hold-off
    initial begin
        int  run_len;
        int  bias;
        bit  held;
        held = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (squeeze && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            run_len = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0: bias = 0;
                1: bias = 30;
                2: bias = 70;
                default: bias = 100;
            endcase
            repeat (run_len) begin
                m_ready <= ($urandom_range(1, 100) <= bias);
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_x_lo    <= '0;
        s_x_hi    <= '0;
        s_acc_lo  <= '0;
        s_acc_hi  <= '0;
        squeeze   <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // multiplier still zero from reset
        offer(ALL_ONES, ALL_ONES, '0, '0);
        offer('0, '0, ALL_ONES, ALL_ONES);
        offer(ALT_A, ALT_5, ALT_5, ALT_A);
        settle();
        write_reg(REG_SPARE_LAST, ALL_ONES);
        write_reg(REG_SPARE_FIRST, ALL_ONES);
        offer(ALL_ONES, ALL_ONES, ALT_A, ALT_5);

        // identity multiplier
        load_multiplier(UNIT, '0);
        offer(ALT_A, ALT_5, '0, '0);
        offer(TOP_BIT, UNIT, ALL_ONES, '0);
        offer(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);

        // x^127, heaviest reduction
        load_multiplier('0, TOP_BIT);
        offer('0, TOP_BIT, '0, '0);
        offer(UNIT << 1, '0, '0, '0);
        offer(ALL_ONES, ALL_ONES, '0, '0);
        offer(UNIT, '0, ALT_A, ALT_A);

        load_multiplier(ALL_ONES, ALL_ONES);
        offer(ALL_ONES, ALL_ONES, '0, '0);
        offer(TOP_BIT, TOP_BIT, ALL_ONES, ALL_ONES);
        offer(ALT_5, ALT_A, '0, '0);
        offer('0, '0, '0, '0);

        load_multiplier(pick_word(), pick_word());
        run_random(220);
        load_multiplier(ALL_ONES, ALL_ONES);
        run_random(200);
        load_multiplier({$urandom, $urandom}, {$urandom, $urandom});
        squeeze <= 1'b1;
        run_random(220);
        load_multiplier('0, '0);
        run_random(180);
        load_multiplier({$urandom, $urandom}, {$urandom, $urandom});
        run_random(230);
        settle();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/gfm_pkg.sv
hw/rtl/gfm_mul_stage.sv
hw/rtl/gfm_fold_stage.sv
hw/rtl/gfm_out_stage.sv
hw/rtl/gf2_128_multiply_accumulate.sv
sim/gfm_mac_checker.sv
sim/tb.sv
